// ----- sv/pdc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdc_pkg: shared definitions for the Porter-Duff pixel compositor
// Field widths, mode and register codes, the coefficient table and the
// fixed-point helpers used by the datapath and the channel interfaces.
// ----------------------------------------------------------------------------
package pdc_pkg;

  // Field widths.
  localparam int CH_W       = 8;
  localparam int COORD_W    = 12;
  localparam int SIZE_W     = 13;
  localparam int Q_W        = 17;
  localparam int WGT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int N_COLOR    = 3;

  // One in unsigned Q16.
  localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

  // Compositing modes.
  localparam logic [3:0] MODE_SRC      = 4'd0;
  localparam logic [3:0] MODE_DST      = 4'd1;
  localparam logic [3:0] MODE_SRC_OVER = 4'd2;
  localparam logic [3:0] MODE_DST_OVER = 4'd3;
  localparam logic [3:0] MODE_SRC_IN   = 4'd4;
  localparam logic [3:0] MODE_DST_IN   = 4'd5;
  localparam logic [3:0] MODE_SRC_OUT  = 4'd6;
  localparam logic [3:0] MODE_DST_OUT  = 4'd7;
  localparam logic [3:0] MODE_SRC_ATOP = 4'd8;
  localparam logic [3:0] MODE_DST_ATOP = 4'd9;
  localparam logic [3:0] MODE_CLEAR    = 4'd10;
  localparam logic [3:0] MODE_XOR      = 4'd11;
  localparam logic [3:0] MODE_BLEND    = 4'd12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HAS_ALPHA = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HAS_ALPHA  = 3'd7;

  // Base color select.
  localparam logic [1:0] BASE_ZERO = 2'd0;
  localparam logic [1:0] BASE_SRC  = 2'd1;
  localparam logic [1:0] BASE_DST  = 2'd2;

  // Porter-Duff coefficients of one mode.
  typedef struct packed {
    logic [1:0] base_sel;
    logic       cx;
    logic       cy;
    logic       cz;
  } pd_coef_t;

  // Coefficient table; clear, blend and the unused codes share the default arm.
  function automatic pd_coef_t pd_lookup(input logic [3:0] mode);
    pd_coef_t c;
    case (mode)
      MODE_SRC:      c = '{BASE_SRC,  1'b1, 1'b1, 1'b0};
      MODE_DST:      c = '{BASE_DST,  1'b1, 1'b0, 1'b1};
      MODE_SRC_OVER: c = '{BASE_SRC,  1'b1, 1'b1, 1'b1};
      MODE_DST_OVER: c = '{BASE_DST,  1'b1, 1'b1, 1'b1};
      MODE_SRC_IN:   c = '{BASE_SRC,  1'b1, 1'b0, 1'b0};
      MODE_DST_IN:   c = '{BASE_DST,  1'b1, 1'b0, 1'b0};
      MODE_SRC_OUT:  c = '{BASE_ZERO, 1'b0, 1'b1, 1'b0};
      MODE_DST_OUT:  c = '{BASE_ZERO, 1'b0, 1'b0, 1'b1};
      MODE_SRC_ATOP: c = '{BASE_SRC,  1'b1, 1'b0, 1'b1};
      MODE_DST_ATOP: c = '{BASE_DST,  1'b1, 1'b1, 1'b0};
      MODE_XOR:      c = '{BASE_ZERO, 1'b0, 1'b1, 1'b1};
      default:       c = '{BASE_ZERO, 1'b0, 1'b0, 1'b0};
    endcase
    return c;
  endfunction

  // floor(a * 65536 / 255) = a * 257 + (a == 255).
  function automatic logic [Q_W-1:0] alpha_q16(input logic [CH_W-1:0] a);
    return {1'b0, a, a} + Q_W'(a == 8'hFF);
  endfunction

  // floor(pct * 65536 / 100) with pct clamped to 100. 65536 = 655 * 100 + 36,
  // and floor(pct * 36 / 100) = (pct * 369) >> 10 holds for pct up to 100.
  function automatic logic [Q_W-1:0] opacity_to_q16(input logic [6:0] pct);
    logic [6:0]     p;
    logic [Q_W-1:0] whole;
    logic [15:0]    frac;
    p     = (pct > 7'd100) ? 7'd100 : pct;
    whole = Q_W'(p) * 17'd655;
    frac  = 16'(p) * 16'd369;
    return whole + Q_W'(frac[15:10]);
  endfunction

  // Opacity times 255, used to scale the Porter-Duff alpha sum.
  function automatic logic [WGT_W-1:0] opacity_weight(input logic [Q_W-1:0] t);
    logic [WGT_W:0] prod;
    prod = {t, 8'h00} - {8'h00, t};
    return prod[WGT_W-1:0];
  endfunction

endpackage

// ----- sv/pdc_in_if.sv -----
// ----------------------------------------------------------------------------
// pdc_in_if: input pixel channel
// Destination pixel with its coordinates and the co-located source pixel.
// ----------------------------------------------------------------------------
interface pdc_in_if;
  logic                     valid;
  logic                     ready;
  logic [pdc_pkg::COORD_W-1:0] pixel_x;
  logic [pdc_pkg::COORD_W-1:0] pixel_y;
  logic [pdc_pkg::CH_W-1:0] dst_red;
  logic [pdc_pkg::CH_W-1:0] dst_green;
  logic [pdc_pkg::CH_W-1:0] dst_blue;
  logic [pdc_pkg::CH_W-1:0] dst_alpha;
  logic [pdc_pkg::CH_W-1:0] src_red;
  logic [pdc_pkg::CH_W-1:0] src_green;
  logic [pdc_pkg::CH_W-1:0] src_blue;
  logic [pdc_pkg::CH_W-1:0] src_alpha;

  modport source (
    output valid, pixel_x, pixel_y, dst_red, dst_green, dst_blue, dst_alpha,
           src_red, src_green, src_blue, src_alpha,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, dst_red, dst_green, dst_blue, dst_alpha,
           src_red, src_green, src_blue, src_alpha,
    output ready
  );
endinterface

// ----- sv/pdc_out_if.sv -----
// ----------------------------------------------------------------------------
// pdc_out_if: output pixel channel
// Composited pixel and the saturation flag.
// ----------------------------------------------------------------------------
interface pdc_out_if;
  logic                     valid;
  logic                     ready;
  logic [pdc_pkg::CH_W-1:0] out_red;
  logic [pdc_pkg::CH_W-1:0] out_green;
  logic [pdc_pkg::CH_W-1:0] out_blue;
  logic [pdc_pkg::CH_W-1:0] out_alpha;
  logic                     clipped;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, clipped,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, clipped,
    output ready
  );
endinterface

// ----- sv/porter_duff_pixel_compositor.sv -----
// ----------------------------------------------------------------------------
// porter_duff_pixel_compositor: pipelined Porter-Duff compositor
// Combines one destination pixel with the co-located source pixel per item
// in one of twelve Porter-Duff modes or a plain opacity blend.
//
//   Channel   Dir  Handshake      Content
//   in_pix    in   valid/ready    coordinates, destination and source RGBA
//   out_pix   out  valid/ready    composited RGBA and clipped flag
//   cfg_*     in   write enable   mode, opacity, window, alpha enables
//
// One item per clock sustained while the output is not stalled; five register
// stages (window test, products, sums, alpha scaling, final) lead to the output
// register. Reset is synchronous; it clears the valid bits and loads the
// configuration registers with their defaults. A stalled output holds its item;
// a stage loads whenever it is empty or its successor moves, so bubbles are
// squeezed out and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module porter_duff_pixel_compositor (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  pdc_in_if.sink                             in_pix,
  pdc_out_if.source                          out_pix
);

  // Configuration registers.
  logic [3:0]                       mode_r;
  logic [pdc_pkg::Q_W-1:0]          t_r;
  logic [pdc_pkg::WGT_W-1:0]        w_r;
  logic [pdc_pkg::COORD_W-1:0]      offset_x_r;
  logic [pdc_pkg::COORD_W-1:0]      offset_y_r;
  logic [pdc_pkg::SIZE_W-1:0]       src_width_r;
  logic [pdc_pkg::SIZE_W-1:0]       src_height_r;
  logic                             dest_has_alpha_r;
  logic                             src_has_alpha_r;

  // Stage valid bits and load enables.
  logic a_v_r, b_v_r, c_v_r, d_v_r, o_v_r;
  logic load_a, load_b, load_c, load_d, load_o;

  // Stage A: window test and alpha conversion.
  logic [pdc_pkg::COORD_W+1:0]  x_end, y_end;
  logic                         a_inside_nxt, a_inside_r;
  logic                         a_blend_nxt, a_blend_r;
  pdc_pkg::pd_coef_t            a_coef_nxt, a_coef_r;
  logic [pdc_pkg::CH_W-1:0]     a_sa8_nxt, a_sa8_r, a_da8_nxt, a_da8_r;
  logic [pdc_pkg::Q_W-1:0]      a_as_nxt, a_as_r, a_ad_nxt, a_ad_r;
  logic [pdc_pkg::CH_W-1:0]     a_cs_nxt [pdc_pkg::N_COLOR];
  logic [pdc_pkg::CH_W-1:0]     a_cs_r   [pdc_pkg::N_COLOR];
  logic [pdc_pkg::CH_W-1:0]     a_cd_nxt [pdc_pkg::N_COLOR];
  logic [pdc_pkg::CH_W-1:0]     a_cd_r   [pdc_pkg::N_COLOR];

  // Stage B: products.
  logic [pdc_pkg::Q_W-1:0]      inv_as, inv_ad, inv_t;
  logic [32:0]                  b_p_nxt, b_p_r, b_ay_nxt, b_ay_r, b_az_nxt, b_az_r;
  logic [24:0]                  b_ty_nxt [pdc_pkg::N_COLOR];
  logic [24:0]                  b_ty_r   [pdc_pkg::N_COLOR];
  logic [24:0]                  b_tz_nxt [pdc_pkg::N_COLOR];
  logic [24:0]                  b_tz_r   [pdc_pkg::N_COLOR];
  logic [pdc_pkg::CH_W-1:0]     b_base_nxt [pdc_pkg::N_COLOR];
  logic [pdc_pkg::CH_W-1:0]     b_base_r   [pdc_pkg::N_COLOR];
  logic [23:0]                  b_bl_nxt [pdc_pkg::N_COLOR+1];
  logic [23:0]                  b_bl_r   [pdc_pkg::N_COLOR+1];
  logic [pdc_pkg::CH_W-1:0]     b_cd_r   [pdc_pkg::N_COLOR+1];
  logic                         b_inside_r, b_blend_r;
  pdc_pkg::pd_coef_t            b_coef_r;

  // Stage C: sums.
  logic [39:0]                  c_bp_nxt [pdc_pkg::N_COLOR];
  logic [39:0]                  c_bp_r   [pdc_pkg::N_COLOR];
  logic [25:0]                  c_ts_nxt [pdc_pkg::N_COLOR];
  logic [25:0]                  c_ts_r   [pdc_pkg::N_COLOR];
  logic [33:0]                  c_asum_nxt, c_asum_r;
  logic [pdc_pkg::CH_W-1:0]     c_bl_nxt [pdc_pkg::N_COLOR+1];
  logic [pdc_pkg::CH_W-1:0]     c_bl_r   [pdc_pkg::N_COLOR+1];
  logic                         c_blend_r;

  // Stage D: color results and alpha scaling products.
  logic [41:0]                  acc [pdc_pkg::N_COLOR];
  logic [9:0]                   col_hi [pdc_pkg::N_COLOR];
  logic [pdc_pkg::CH_W-1:0]     d_col_nxt [pdc_pkg::N_COLOR];
  logic [pdc_pkg::CH_W-1:0]     d_col_r   [pdc_pkg::N_COLOR];
  logic                         d_clip_nxt, d_clip_r;
  logic [41:0]                  d_ahi_nxt, d_ahi_r;
  logic [39:0]                  d_alo_nxt, d_alo_r;
  logic [pdc_pkg::CH_W-1:0]     d_bl_r [pdc_pkg::N_COLOR+1];
  logic                         d_blend_r;

  // Output stage.
  logic [58:0]                  aprod;
  logic [10:0]                  alpha_hi;
  logic [pdc_pkg::CH_W-1:0]     o_red_nxt, o_green_nxt, o_blue_nxt, o_alpha_nxt;
  logic [pdc_pkg::CH_W-1:0]     o_red_r, o_green_r, o_blue_r, o_alpha_r;
  logic                         o_clip_nxt, o_clip_r;

  // Configuration writes; opacity is kept as Q16 and as Q16 times 255.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= pdc_pkg::MODE_SRC;
      t_r              <= pdc_pkg::opacity_to_q16(7'd50);
      w_r              <= pdc_pkg::opacity_weight(pdc_pkg::opacity_to_q16(7'd50));
      offset_x_r       <= '0;
      offset_y_r       <= '0;
      src_width_r      <= pdc_pkg::SIZE_W'(1);
      src_height_r     <= pdc_pkg::SIZE_W'(1);
      dest_has_alpha_r <= 1'b0;
      src_has_alpha_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pdc_pkg::REG_MODE: begin
          mode_r <= cfg_wdata[3:0];
        end
        pdc_pkg::REG_OPACITY: begin
          t_r <= pdc_pkg::opacity_to_q16(cfg_wdata[6:0]);
          w_r <= pdc_pkg::opacity_weight(pdc_pkg::opacity_to_q16(cfg_wdata[6:0]));
        end
        pdc_pkg::REG_OFFSET_X: begin
          offset_x_r <= cfg_wdata[pdc_pkg::COORD_W-1:0];
        end
        pdc_pkg::REG_OFFSET_Y: begin
          offset_y_r <= cfg_wdata[pdc_pkg::COORD_W-1:0];
        end
        pdc_pkg::REG_SRC_WIDTH: begin
          src_width_r <= cfg_wdata;
        end
        pdc_pkg::REG_SRC_HEIGHT: begin
          src_height_r <= cfg_wdata;
        end
        pdc_pkg::REG_DEST_HAS_ALPHA: begin
          dest_has_alpha_r <= cfg_wdata[0];
        end
        pdc_pkg::REG_SRC_HAS_ALPHA: begin
          src_has_alpha_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // A stage loads when it is empty or its successor moves on.
  assign load_o       = !o_v_r || out_pix.ready;
  assign load_d       = !d_v_r || load_o;
  assign load_c       = !c_v_r || load_d;
  assign load_b       = !b_v_r || load_c;
  assign load_a       = !a_v_r || load_b;
  assign in_pix.ready = load_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (load_a) begin
        a_v_r <= in_pix.valid;
      end
      if (load_b) begin
        b_v_r <= a_v_r;
      end
      if (load_c) begin
        c_v_r <= b_v_r;
      end
      if (load_d) begin
        d_v_r <= c_v_r;
      end
      if (load_o) begin
        o_v_r <= d_v_r;
      end
    end
  end

  // Stage A: source window test, alpha to Q16, mode decode. Coordinates are
  // 12 bits wide and the coordinate range is 4096, so they need no reduction.
  always_comb begin
    x_end = {2'b00, offset_x_r} + {1'b0, src_width_r};
    y_end = {2'b00, offset_y_r} + {1'b0, src_height_r};
    a_inside_nxt = (in_pix.pixel_x >= offset_x_r) && (in_pix.pixel_y >= offset_y_r) &&
                   ({2'b00, in_pix.pixel_x} < x_end) && ({2'b00, in_pix.pixel_y} < y_end);
    a_blend_nxt = (mode_r == pdc_pkg::MODE_BLEND);
    a_coef_nxt  = pdc_pkg::pd_lookup(mode_r);
    a_sa8_nxt   = src_has_alpha_r  ? in_pix.src_alpha : 8'hFF;
    a_da8_nxt   = dest_has_alpha_r ? in_pix.dst_alpha : 8'hFF;
    a_ad_nxt    = dest_has_alpha_r ? pdc_pkg::alpha_q16(in_pix.dst_alpha) : pdc_pkg::ONE_Q16;
    if (!a_inside_nxt) begin
      a_as_nxt = '0;
    end else if (src_has_alpha_r) begin
      a_as_nxt = pdc_pkg::alpha_q16(in_pix.src_alpha);
    end else begin
      a_as_nxt = pdc_pkg::ONE_Q16;
    end
    // Outside the window the source is transparent black.
    a_cs_nxt[0] = a_inside_nxt ? in_pix.src_red   : '0;
    a_cs_nxt[1] = a_inside_nxt ? in_pix.src_green : '0;
    a_cs_nxt[2] = a_inside_nxt ? in_pix.src_blue  : '0;
    a_cd_nxt[0] = in_pix.dst_red;
    a_cd_nxt[1] = in_pix.dst_green;
    a_cd_nxt[2] = in_pix.dst_blue;
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_inside_r <= a_inside_nxt;
      a_blend_r  <= a_blend_nxt;
      a_coef_r   <= a_coef_nxt;
      a_sa8_r    <= a_sa8_nxt;
      a_da8_r    <= a_da8_nxt;
      a_as_r     <= a_as_nxt;
      a_ad_r     <= a_ad_nxt;
      a_cs_r     <= a_cs_nxt;
      a_cd_r     <= a_cd_nxt;
    end
  end

  // Stage B: alpha product, complement products and blend products.
  always_comb begin
    inv_as   = pdc_pkg::ONE_Q16 - a_as_r;
    inv_ad   = pdc_pkg::ONE_Q16 - a_ad_r;
    inv_t    = pdc_pkg::ONE_Q16 - t_r;
    b_p_nxt  = 33'(a_as_r) * 33'(a_ad_r);
    b_ay_nxt = 33'(a_as_r) * 33'(inv_ad);
    b_az_nxt = 33'(a_ad_r) * 33'(inv_as);
    for (int k = 0; k < pdc_pkg::N_COLOR; k++) begin
      b_ty_nxt[k] = 25'(a_cs_r[k]) * 25'(inv_ad);
      b_tz_nxt[k] = 25'(a_cd_r[k]) * 25'(inv_as);
      b_bl_nxt[k] = 24'(a_cs_r[k]) * 24'(t_r) + 24'(a_cd_r[k]) * 24'(inv_t);
      case (a_coef_r.base_sel)
        pdc_pkg::BASE_SRC: b_base_nxt[k] = a_cs_r[k];
        pdc_pkg::BASE_DST: b_base_nxt[k] = a_cd_r[k];
        default:           b_base_nxt[k] = '0;
      endcase
    end
    b_bl_nxt[pdc_pkg::N_COLOR] = 24'(a_sa8_r) * 24'(t_r) + 24'(a_da8_r) * 24'(inv_t);
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_p_r      <= b_p_nxt;
      b_ay_r     <= b_ay_nxt;
      b_az_r     <= b_az_nxt;
      b_ty_r     <= b_ty_nxt;
      b_tz_r     <= b_tz_nxt;
      b_base_r   <= b_base_nxt;
      b_bl_r     <= b_bl_nxt;
      b_cd_r[0]  <= a_cd_r[0];
      b_cd_r[1]  <= a_cd_r[1];
      b_cd_r[2]  <= a_cd_r[2];
      b_cd_r[3]  <= a_da8_r;
      b_inside_r <= a_inside_r;
      b_blend_r  <= a_blend_r;
      b_coef_r   <= a_coef_r;
    end
  end

  // Stage C: base color product, weighted sums, blend result. The blend sum
  // never exceeds 255 in its top byte; outside the window it copies the
  // destination.
  always_comb begin
    for (int k = 0; k < pdc_pkg::N_COLOR; k++) begin
      c_bp_nxt[k] = 40'(b_base_r[k]) * 40'(b_p_r);
      c_ts_nxt[k] = (b_coef_r.cy ? 26'(b_ty_r[k]) : 26'd0) +
                    (b_coef_r.cz ? 26'(b_tz_r[k]) : 26'd0);
    end
    c_asum_nxt = (b_coef_r.cx ? 34'(b_p_r)  : 34'd0) +
                 (b_coef_r.cy ? 34'(b_ay_r) : 34'd0) +
                 (b_coef_r.cz ? 34'(b_az_r) : 34'd0);
    for (int k = 0; k <= pdc_pkg::N_COLOR; k++) begin
      c_bl_nxt[k] = b_inside_r ? b_bl_r[k][23:16] : b_cd_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (load_c) begin
      c_bp_r    <= c_bp_nxt;
      c_ts_r    <= c_ts_nxt;
      c_asum_r  <= c_asum_nxt;
      c_bl_r    <= c_bl_nxt;
      c_blend_r <= b_blend_r;
    end
  end

  // Stage D: color accumulate and saturate; alpha sum times opacity weight,
  // split in two partial products.
  always_comb begin
    d_clip_nxt = 1'b0;
    for (int k = 0; k < pdc_pkg::N_COLOR; k++) begin
      acc[k]    = 42'(c_bp_r[k]) + {c_ts_r[k], 16'h0000};
      col_hi[k] = acc[k][41:32];
      if (col_hi[k] > 10'd255) begin
        d_col_nxt[k] = 8'hFF;
        d_clip_nxt   = 1'b1;
      end else begin
        d_col_nxt[k] = col_hi[k][7:0];
      end
    end
    d_ahi_nxt = 42'(c_asum_r[33:16]) * 42'(w_r);
    d_alo_nxt = 40'(c_asum_r[15:0]) * 40'(w_r);
  end

  always_ff @(posedge clk) begin
    if (load_d) begin
      d_col_r   <= d_col_nxt;
      d_clip_r  <= d_clip_nxt;
      d_ahi_r   <= d_ahi_nxt;
      d_alo_r   <= d_alo_nxt;
      d_bl_r    <= c_bl_r;
      d_blend_r <= c_blend_r;
    end
  end

  // Output stage: finish the alpha, saturate and pick the blend or
  // Porter-Duff result.
  always_comb begin
    aprod    = 59'({d_ahi_r, 16'h0000}) + 59'(d_alo_r);
    alpha_hi = aprod[58:48];
    if (d_blend_r) begin
      o_red_nxt   = d_bl_r[0];
      o_green_nxt = d_bl_r[1];
      o_blue_nxt  = d_bl_r[2];
      o_alpha_nxt = d_bl_r[3];
      o_clip_nxt  = 1'b0;
    end else begin
      o_red_nxt   = d_col_r[0];
      o_green_nxt = d_col_r[1];
      o_blue_nxt  = d_col_r[2];
      o_alpha_nxt = (alpha_hi > 11'd255) ? 8'hFF : alpha_hi[7:0];
      o_clip_nxt  = d_clip_r || (alpha_hi > 11'd255);
    end
  end

  always_ff @(posedge clk) begin
    if (load_o) begin
      o_red_r   <= o_red_nxt;
      o_green_r <= o_green_nxt;
      o_blue_r  <= o_blue_nxt;
      o_alpha_r <= o_alpha_nxt;
      o_clip_r  <= o_clip_nxt;
    end
  end

  assign out_pix.valid     = o_v_r;
  assign out_pix.out_red   = o_red_r;
  assign out_pix.out_green = o_green_r;
  assign out_pix.out_blue  = o_blue_r;
  assign out_pix.out_alpha = o_alpha_r;
  assign out_pix.clipped   = o_clip_r;

endmodule
